[rtl/h264_rtp_depacketizer_macros.svh]
// ----------------------------------------------------------------------------
// h264_rtp_depacketizer_macros
// Assertion macros for the H.264 RTP depacketizer.
// ----------------------------------------------------------------------------
`ifndef H264_RTP_DEPACKETIZER_MACROS_SVH
`define H264_RTP_DEPACKETIZER_MACROS_SVH

`ifndef ASSERT_OFF
`define H264RTP_ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("h264rtp assertion failed");
`define H264RTP_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("h264rtp forbidden condition");
`else
`define H264RTP_ASSERT_PROP(label, clk, rst, prop)
`define H264RTP_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

[rtl/h264rtp_pkg.sv]
// ----------------------------------------------------------------------------
// h264rtp_pkg
// Types and constants shared by the H.264 RTP depacketizer modules.
// ----------------------------------------------------------------------------
package h264rtp_pkg;

  localparam logic [7:0] HEADER_LENGTH_RESET = 8'd12;
  localparam logic [4:0] NAL_TYPE_FUA        = 5'd28;
  localparam logic [4:0] NAL_TYPE_SINGLE_MAX = 5'd23;
  localparam logic [4:0] NAL_TYPE_SINGLE_MIN = 5'd1;
  localparam logic [8:0] POSITION_MAX        = 9'd511;
  localparam logic [7:0] START_CODE_ZERO     = 8'h00;
  localparam logic [7:0] START_CODE_ONE      = 8'h01;
  localparam int unsigned FU_START_BIT       = 7;
  localparam int unsigned FU_END_BIT         = 6;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_FUA    = 2'd2,
    KIND_DROP   = 2'd3
  } packet_kind_t;

  typedef enum logic [1:0] {
    OP_DROP  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_BYTE  = 2'd2,
    OP_START = 2'd3
  } cmd_op_t;

  typedef enum logic [2:0] {
    STEP_SC0  = 3'd0,
    STEP_SC1  = 3'd1,
    STEP_SC2  = 3'd2,
    STEP_SC3  = 3'd3,
    STEP_DATA = 3'd4
  } step_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic       nal_last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       nal_first;
    logic       nal_last;
    logic       packet_dropped;
    logic       burst_last;
  } out_item_t;

endpackage

[rtl/h264rtp_front.sv]
// ----------------------------------------------------------------------------
// h264rtp_front
// Tracks packet position and type; each input beat gives at most one command.
// ----------------------------------------------------------------------------
module h264rtp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  h264rtp_pkg::in_item_t in_data,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output h264rtp_pkg::cmd_t     cmd
);

  logic [7:0]                header_length;
  logic [8:0]                byte_position;
  h264rtp_pkg::packet_kind_t packet_kind;
  logic [2:0]                fu_nri_bits;
  logic                      fu_end_seen;

  logic [8:0]                byte_position_next;
  h264rtp_pkg::packet_kind_t packet_kind_next;
  logic [2:0]                fu_nri_bits_next;
  logic                      fu_end_seen_next;

  logic       accept;
  logic       emit;
  logic [8:0] hdr_pos;
  logic [8:0] fu_pos;
  logic [4:0] nal_type;
  logic [7:0] b;
  logic       last;

  assign cfg_ready = 1'b1;
  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = accept && emit;

  assign b        = in_data.in_byte;
  assign last     = in_data.packet_last;
  assign nal_type = b[4:0];
  assign hdr_pos  = {1'b0, header_length};
  assign fu_pos   = hdr_pos + 9'd1;

  always_comb begin
    emit             = 1'b0;
    cmd.op           = h264rtp_pkg::OP_DROP;
    cmd.data         = b;
    cmd.nal_last     = 1'b0;
    packet_kind_next = packet_kind;
    fu_nri_bits_next = fu_nri_bits;
    fu_end_seen_next = fu_end_seen;
    if (byte_position < hdr_pos) begin
      emit = last;
    end else if (byte_position == hdr_pos) begin
      if (nal_type >= h264rtp_pkg::NAL_TYPE_SINGLE_MIN &&
          nal_type <= h264rtp_pkg::NAL_TYPE_SINGLE_MAX) begin
        packet_kind_next = h264rtp_pkg::KIND_SINGLE;
        emit             = 1'b1;
        cmd.op           = h264rtp_pkg::OP_START;
        cmd.nal_last     = last;
      end else if (nal_type == h264rtp_pkg::NAL_TYPE_FUA) begin
        packet_kind_next = h264rtp_pkg::KIND_FUA;
        fu_nri_bits_next = b[7:5];
        emit             = last;
      end else begin
        packet_kind_next = h264rtp_pkg::KIND_DROP;
        emit             = last;
      end
    end else begin
      unique case (packet_kind)
        h264rtp_pkg::KIND_SINGLE: begin
          emit         = 1'b1;
          cmd.op       = h264rtp_pkg::OP_BYTE;
          cmd.nal_last = last;
        end
        h264rtp_pkg::KIND_FUA: begin
          if (byte_position == fu_pos) begin
            fu_end_seen_next = b[h264rtp_pkg::FU_END_BIT];
            if (b[h264rtp_pkg::FU_START_BIT]) begin
              emit         = 1'b1;
              cmd.op       = h264rtp_pkg::OP_START;
              cmd.data     = {fu_nri_bits, nal_type};
              cmd.nal_last = last && b[h264rtp_pkg::FU_END_BIT];
            end else if (last && b[h264rtp_pkg::FU_END_BIT]) begin
              emit         = 1'b1;
              cmd.op       = h264rtp_pkg::OP_CLOSE;
              cmd.nal_last = 1'b1;
            end
          end else begin
            emit         = 1'b1;
            cmd.op       = h264rtp_pkg::OP_BYTE;
            cmd.nal_last = last && fu_end_seen;
          end
        end
        default: begin
          emit = last;
        end
      endcase
    end
    if (last) begin
      byte_position_next = '0;
      packet_kind_next   = h264rtp_pkg::KIND_NONE;
      fu_nri_bits_next   = '0;
      fu_end_seen_next   = 1'b0;
    end else if (byte_position < h264rtp_pkg::POSITION_MAX) begin
      byte_position_next = byte_position + 9'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_length <= h264rtp_pkg::HEADER_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      packet_kind   <= h264rtp_pkg::KIND_NONE;
      fu_nri_bits   <= '0;
      fu_end_seen   <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      packet_kind   <= packet_kind_next;
      fu_nri_bits   <= fu_nri_bits_next;
      fu_end_seen   <= fu_end_seen_next;
    end
  end

endmodule

[rtl/h264rtp_queue.sv]
// ----------------------------------------------------------------------------
// h264rtp_queue
// Small command FIFO between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module h264rtp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  h264rtp_pkg::cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output h264rtp_pkg::cmd_t pop_cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

  h264rtp_pkg::cmd_t slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != COUNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/h264rtp_back.sv]
// ----------------------------------------------------------------------------
// h264rtp_back
// Expands queued commands into output beats: start codes, data, markers.
// ----------------------------------------------------------------------------
module h264rtp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  h264rtp_pkg::cmd_t      cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output h264rtp_pkg::out_item_t out_data
);

  h264rtp_pkg::cmd_t  cur;
  logic               cur_valid;
  h264rtp_pkg::step_t step;
  h264rtp_pkg::step_t step_next;
  logic               final_step;
  logic               advance;

  assign final_step = (cur.op != h264rtp_pkg::OP_START) || (step == h264rtp_pkg::STEP_DATA);
  assign advance    = !cur_valid || (out_ready && final_step);
  assign cmd_ready  = advance;
  assign out_valid  = cur_valid;

  always_comb begin
    unique case (step)
      h264rtp_pkg::STEP_SC0: step_next = h264rtp_pkg::STEP_SC1;
      h264rtp_pkg::STEP_SC1: step_next = h264rtp_pkg::STEP_SC2;
      h264rtp_pkg::STEP_SC2: step_next = h264rtp_pkg::STEP_SC3;
      default:               step_next = h264rtp_pkg::STEP_DATA;
    endcase
  end

  always_comb begin
    out_data                = '0;
    out_data.burst_last     = final_step;
    unique case (cur.op)
      h264rtp_pkg::OP_START: begin
        out_data.byte_valid = 1'b1;
        unique case (step)
          h264rtp_pkg::STEP_SC0: begin
            out_data.out_byte  = h264rtp_pkg::START_CODE_ZERO;
            out_data.nal_first = 1'b1;
          end
          h264rtp_pkg::STEP_SC1: out_data.out_byte = h264rtp_pkg::START_CODE_ZERO;
          h264rtp_pkg::STEP_SC2: out_data.out_byte = h264rtp_pkg::START_CODE_ZERO;
          h264rtp_pkg::STEP_SC3: out_data.out_byte = h264rtp_pkg::START_CODE_ONE;
          default: begin
            out_data.out_byte = cur.data;
            out_data.nal_last = cur.nal_last;
          end
        endcase
      end
      h264rtp_pkg::OP_BYTE: begin
        out_data.out_byte   = cur.data;
        out_data.byte_valid = 1'b1;
        out_data.nal_last   = cur.nal_last;
      end
      h264rtp_pkg::OP_CLOSE: begin
        out_data.nal_last = 1'b1;
      end
      h264rtp_pkg::OP_DROP: begin
        out_data.packet_dropped = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (advance && cmd_valid) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= h264rtp_pkg::STEP_SC0;
    end else if (advance) begin
      cur_valid <= cmd_valid;
      step      <= h264rtp_pkg::STEP_SC0;
    end else if (out_ready) begin
      step      <= step_next;
    end
  end

endmodule

[rtl/h264_rtp_depacketizer.sv]
// ----------------------------------------------------------------------------
// h264_rtp_depacketizer
// RTP (single NAL and FU-A) to Annex-B H.264 byte stream converter.
// Throughput: 1 input beat per cycle unless the queue is full; a beat opening a NAL
// unit yields 5 beats, limited by the output sequencer's one beat per ready cycle.
// Reset: synchronous; clears packet state, queue and output; header_length = 12.
// ----------------------------------------------------------------------------
`include "h264_rtp_depacketizer_macros.svh"

module h264_rtp_depacketizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  h264rtp_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output h264rtp_pkg::out_item_t out_data
);

  logic              f_valid;
  logic              f_ready;
  h264rtp_pkg::cmd_t f_cmd;
  logic              q_valid;
  logic              q_ready;
  h264rtp_pkg::cmd_t q_cmd;

  h264rtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  h264rtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  h264rtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `H264RTP_ASSERT_PROP(a_first_is_zero, clk, rst, out_valid && out_data.nal_first |-> out_data.byte_valid && out_data.out_byte == 8'h00 && !out_data.burst_last)
  `H264RTP_ASSERT_PROP(a_marker_ends_burst, clk, rst, out_valid && !out_data.byte_valid |-> out_data.burst_last)
  `H264RTP_ASSERT_NEVER(a_drop_no_data, clk, rst, out_valid && out_data.packet_dropped && (out_data.byte_valid || out_data.nal_last))
  `H264RTP_ASSERT_PROP(a_first_then_zero, clk, rst, out_valid && out_ready && out_data.nal_first |=> out_valid && out_data.out_byte == 8'h00 && !out_data.nal_first)

endmodule

[verif/h264_rtp_depacketizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_depacketizer_test
// Drives RTP packets byte by byte into the depacketizer. A local model of the
// converter predicts the Annex-B beats, and each output beat is checked field
// by field. It covers single NAL, FU-A and dropped packets, header lengths 0-4,
// 12 and 255, random sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module h264_rtp_depacketizer_test;

  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_BEATS  = 35;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [7:0]             cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  h264rtp_pkg::in_item_t  in_data;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  h264rtp_pkg::out_item_t out_data;

  h264_rtp_depacketizer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // converter model state
  logic [7:0]                hdr_len = h264rtp_pkg::HEADER_LENGTH_RESET;
  logic [8:0]                pos = '0;
  h264rtp_pkg::packet_kind_t kind = h264rtp_pkg::KIND_NONE;
  logic [2:0]                nri = '0;
  logic                      fu_end = 1'b0;
  h264rtp_pkg::out_item_t    annexb_q[$];

  logic [7:0]             pkt_q[$];
  h264rtp_pkg::out_item_t want;
  int unsigned            tx_idle_pct = 0;
  int unsigned            rx_stall_pct = 0;
  int unsigned            rx_hold_len = 0;
  int unsigned            errors = 0;
  int unsigned            cycles = 0;
  int unsigned            beats_in = 0;
  int unsigned            beats_out = 0;
  int unsigned            payload_beats = 0;
  int unsigned            packets_sent = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void put_result(logic [7:0] b, logic v, logic f, logic l, logic d);
    h264rtp_pkg::out_item_t r;
    r.out_byte       = b;
    r.byte_valid     = v;
    r.nal_first      = f;
    r.nal_last       = l;
    r.packet_dropped = d;
    r.burst_last     = 1'b0;
    annexb_q.push_back(r);
  endfunction

  function automatic void put_start_code();
    put_result(h264rtp_pkg::START_CODE_ZERO, 1'b1, 1'b1, 1'b0, 1'b0);
    put_result(h264rtp_pkg::START_CODE_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
    put_result(h264rtp_pkg::START_CODE_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
    put_result(h264rtp_pkg::START_CODE_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void depack_step(logic [7:0] b, logic last);
    int unsigned            n0;
    logic [8:0]             off;
    h264rtp_pkg::out_item_t tail;
    n0 = annexb_q.size();
    if (pos < {1'b0, hdr_len}) begin
      if (last) put_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
    end else begin
      off = pos - {1'b0, hdr_len};
      if (off == 0) begin
        if (b[4:0] >= h264rtp_pkg::NAL_TYPE_SINGLE_MIN &&
            b[4:0] <= h264rtp_pkg::NAL_TYPE_SINGLE_MAX) begin
          kind = h264rtp_pkg::KIND_SINGLE;
          put_start_code();
          put_result(b, 1'b1, 1'b0, last, 1'b0);
        end else if (b[4:0] == h264rtp_pkg::NAL_TYPE_FUA) begin
          kind = h264rtp_pkg::KIND_FUA;
          nri = b[7:5];
          if (last) put_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        end else begin
          kind = h264rtp_pkg::KIND_DROP;
          if (last) put_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        end
      end else if (kind == h264rtp_pkg::KIND_SINGLE) begin
        put_result(b, 1'b1, 1'b0, last, 1'b0);
      end else if (kind == h264rtp_pkg::KIND_FUA) begin
        if (off == 1) begin
          fu_end = b[h264rtp_pkg::FU_END_BIT];
          if (b[h264rtp_pkg::FU_START_BIT]) begin
            put_start_code();
            put_result({nri, b[4:0]}, 1'b1, 1'b0, last && fu_end, 1'b0);
          end else if (last && fu_end) begin
            put_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          end
        end else begin
          put_result(b, 1'b1, 1'b0, last && fu_end, 1'b0);
        end
      end else if (last) begin
        put_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      end
    end
    if (annexb_q.size() > n0) begin
      tail = annexb_q.pop_back();
      tail.burst_last = 1'b1;
      annexb_q.push_back(tail);
    end
    if (last) begin
      pos    = '0;
      kind   = h264rtp_pkg::KIND_NONE;
      nri    = '0;
      fu_end = 1'b0;
    end else if (pos != h264rtp_pkg::POSITION_MAX) begin
      pos = pos + 9'd1;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (annexb_q.size() == 0) begin
        $error("unexpected beat: out_byte %0h", out_data.out_byte);
        errors++;
      end else begin
        want = annexb_q.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("byte_valid", want.byte_valid, out_data.byte_valid);
        check_field("nal_first", want.nal_first, out_data.nal_first);
        check_field("nal_last", want.nal_last, out_data.nal_last);
        check_field("packet_dropped", want.packet_dropped, out_data.packet_dropped);
        check_field("burst_last", want.burst_last, out_data.burst_last);
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (rx_hold_len != 0) begin
      out_ready <= 1'b0;
      rx_hold_len = rx_hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, packet_last: last};
    do begin
      @(posedge clk);
    end while (!in_ready);
    depack_step(b, last);
    beats_in++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_q.size(); i++) begin
      send_beat(pkt_q[i], i == pkt_q.size() - 1);
      if (i >= hdr_len) payload_beats++;
    end
    packets_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (annexb_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_header(input logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    hdr_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_header();
    pkt_q.delete();
    repeat (hdr_len) pkt_q.push_back(8'($urandom));
  endfunction

  function automatic void add_bytes(int unsigned n);
    repeat (n) pkt_q.push_back(8'($urandom));
  endfunction

  task automatic send_single_nal();
    add_header();
    pkt_q.push_back({3'($urandom), 5'($urandom_range(23, 1))});
    add_bytes($urandom_range(8, 0));
    send_packet();
  endtask

  task automatic send_fu_packet(input logic [7:0] fu_hdr, input int unsigned n);
    add_header();
    pkt_q.push_back({3'($urandom), h264rtp_pkg::NAL_TYPE_FUA});
    pkt_q.push_back(fu_hdr);
    add_bytes(n);
    send_packet();
  endtask

  task automatic send_fu_unit();
    logic [4:0]  t;
    int unsigned mids;
    t = 5'($urandom);
    mids = $urandom_range(2, 0);
    send_fu_packet({2'b10, 1'($urandom), t}, $urandom_range(6, 0));
    repeat (mids) send_fu_packet({2'b00, 1'($urandom), t}, $urandom_range(6, 0));
    send_fu_packet({2'b01, 1'($urandom), t}, $urandom_range(6, 0));
  endtask

  task automatic send_fu_noise();
    if ($urandom_range(9) == 0) begin
      add_header();
      pkt_q.push_back({3'($urandom), h264rtp_pkg::NAL_TYPE_FUA});
      send_packet();
    end else begin
      send_fu_packet(8'($urandom), $urandom_range(4, 0));
    end
  endtask

  task automatic send_unsupported();
    logic [4:0] t;
    do begin
      t = 5'($urandom);
    end while ((t >= h264rtp_pkg::NAL_TYPE_SINGLE_MIN && t <= h264rtp_pkg::NAL_TYPE_SINGLE_MAX)
               || t == h264rtp_pkg::NAL_TYPE_FUA);
    add_header();
    pkt_q.push_back({3'($urandom), t});
    add_bytes($urandom_range(5, 0));
    send_packet();
  endtask

  task automatic send_cut_header();
    int unsigned keep;
    add_header();
    keep = $urandom_range(hdr_len, 1);
    while (pkt_q.size() > keep) void'(pkt_q.pop_back());
    send_packet();
  endtask

  task automatic test_reset_header_length();
    add_header();
    pkt_q.push_back(8'h65);
    add_bytes(2);
    send_packet();
    wait_idle();
  endtask

  task automatic test_single_nal_units();
    set_header(8'd0);
    pkt_q = '{8'h01};
    send_packet();
    pkt_q = '{8'h77, 8'hFF, 8'h00};
    send_packet();
    pkt_q = '{8'hE1, 8'h5A};
    send_packet();
  endtask

  task automatic test_fu_a_fragments();
    pkt_q = '{8'hFC, 8'h85, 8'hAA};
    send_packet();
    pkt_q = '{8'h7C, 8'h45, 8'h55};
    send_packet();
    pkt_q = '{8'h5C, 8'hC1};
    send_packet();
    pkt_q = '{8'h1C, 8'h41};
    send_packet();
    pkt_q = '{8'h1C, 8'h01};
    send_packet();
    pkt_q = '{8'h9C, 8'h02, 8'h33};
    send_packet();
    wait_idle();
  endtask

  task automatic test_dropped_packets();
    pkt_q = '{8'h1C};
    send_packet();
    pkt_q = '{8'h00, 8'h12, 8'h34};
    send_packet();
    pkt_q = '{8'hFF};
    send_packet();
    pkt_q = '{8'h18, 8'h99};
    send_packet();
    pkt_q = '{8'h1D};
    send_packet();
    set_header(8'd3);
    pkt_q = '{8'hAB, 8'hCD};
    send_packet();
    wait_idle();
  endtask

  task automatic test_header_length_extremes();
    set_header(8'd255);
    add_header();
    while (pkt_q.size() > 4) void'(pkt_q.pop_back());
    send_packet();
    set_header(8'd0);
    send_single_nal();
    send_fu_unit();
    wait_idle();
  endtask

  task automatic test_output_hold();
    set_header(8'd0);
    @(posedge clk);
    rx_hold_len = 400;
    repeat (10) send_single_nal();
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input logic [7:0] hdr);
    int unsigned stop_at;
    int unsigned pick;
    set_header(hdr);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at = payload_beats + PHASE_BEATS;
    while (payload_beats < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) send_single_nal();
      else if (pick < 75) send_fu_unit();
      else if (pick < 85) send_fu_noise();
      else if (pick < 93) send_unsupported();
      else if (hdr_len != 0) send_cut_header();
      else send_fu_noise();
    end
    wait_idle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_header_length();
    test_single_nal_units();
    test_fu_a_fragments();
    test_dropped_packets();
    test_header_length_extremes();
    test_output_hold();
    test_random_traffic(0, 0, 8'd0);
    test_random_traffic(60, 0, 8'($urandom_range(4, 1)));
    test_random_traffic(0, 60, 8'($urandom_range(4, 0)));
    test_random_traffic(30, 30, 8'd2);
    wait_idle();

    $display("Sent %0d packets (%0d bytes in, %0d stream beats out), header lengths 0 to 255.",
             packets_sent, beats_in, beats_out);
    $display("Single NAL, FU-A and dropped packets under gaps, stalls and a long hold-off.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/h264rtp_pkg.sv
rtl/h264rtp_front.sv
rtl/h264rtp_queue.sv
rtl/h264rtp_back.sv
rtl/h264_rtp_depacketizer.sv
verif/h264_rtp_depacketizer_test.sv
